[sv/hbg_pkg.sv]
// Package for the H-bridge direction and PWM guard.
// Holds widths, register indexes, status and fault codes and the shared types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package hbg_pkg;

    // Timer and duty fraction widths.
    localparam int TIMER_WIDTH    = 16;
    localparam int DUTY_FRAC_BITS = 16;
    localparam int DUTY_W         = DUTY_FRAC_BITS + 1;
    localparam int PROD_W         = DUTY_W + TIMER_WIDTH;
    localparam int CAP_W          = PROD_W - DUTY_FRAC_BITS;
    localparam int DEAD_W         = 16;
    localparam int DIR_W          = 2;
    localparam int PERM_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int FAULT_W        = 3;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_WIDE_W = (TIMER_WIDTH > DUTY_W) ? TIMER_WIDTH : DUTY_W;
    localparam int CFG_DATA_W = (CFG_WIDE_W > DEAD_W) ? CFG_WIDE_W : DEAD_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FULL_SCALE    = 2'd0,
        REG_MAX_DUTY      = 2'd1,
        REG_DEAD_TICKS    = 2'd2,
        REG_RELEASE_LEVEL = 2'd3
    } t_cfg_reg;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = DIR_W + DUTY_W + PERM_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + FAULT_W + TIMER_WIDTH + DIR_W + 3 + DEAD_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Bit positions of the result fields in the master tdata.
    localparam int M_POS_STATUS = 0;
    localparam int M_POS_FAULT  = M_POS_STATUS + STATUS_W;
    localparam int M_POS_CCR    = M_POS_FAULT + FAULT_W;
    localparam int M_POS_DIR    = M_POS_CCR + TIMER_WIDTH;
    localparam int M_POS_A1     = M_POS_DIR + DIR_W;
    localparam int M_POS_A2     = M_POS_A1 + 1;
    localparam int M_POS_STBY   = M_POS_A2 + 1;
    localparam int M_POS_DEAD   = M_POS_STBY + 1;

    // Command codes.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_INIT   = 1'b1;

    // Direction codes (two's complement).
    localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
    localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_BAD  = 2'sb10;
    localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;

    // Permission codes.
    localparam logic [PERM_W-1:0] PERM_SAFE  = 2'd0;
    localparam logic [PERM_W-1:0] PERM_ALLOW = 2'd1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_SAFE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACTIVE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

    // Fault codes.
    localparam logic [FAULT_W-1:0] FLT_NONE      = 3'd0;
    localparam logic [FAULT_W-1:0] FLT_CONFIG    = 3'd1;
    localparam logic [FAULT_W-1:0] FLT_NOT_ARMED = 3'd2;
    localparam logic [FAULT_W-1:0] FLT_STATE     = 3'd3;
    localparam logic [FAULT_W-1:0] FLT_PERM      = 3'd4;
    localparam logic [FAULT_W-1:0] FLT_DUTY      = 3'd5;
    localparam logic [FAULT_W-1:0] FLT_DIR       = 3'd6;

    // Duty of 1.0 in the Q1.DUTY_FRAC_BITS format.
    localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(1) << DUTY_FRAC_BITS;

    // Register values after reset.
    localparam longint RST_FS_VAL = 1000;
    localparam logic [TIMER_WIDTH-1:0] RST_FULL_SCALE    = TIMER_WIDTH'(RST_FS_VAL);
    localparam logic [DUTY_W-1:0]      RST_MAX_DUTY      = DUTY_ONE;
    localparam logic [DEAD_W-1:0]      RST_DEAD_TICKS    = DEAD_W'(1);
    localparam logic                   RST_RELEASE_LEVEL = 1'b0;
    localparam logic [CAP_W-1:0]       RST_CAP =
        CAP_W'((RST_FS_VAL * (longint'(1) << DUTY_FRAC_BITS)) >> DUTY_FRAC_BITS);

    // Configuration registers together with the values derived from them.
    typedef struct packed {
        logic [TIMER_WIDTH-1:0] full_scale;
        logic [DUTY_W-1:0]      max_duty;
        logic [DEAD_W-1:0]      dead_ticks;
        logic                   release_level;
        logic [CAP_W-1:0]       cap;     // floor(max_duty * full_scale) in counts
        logic [PROD_W-1:0]      lim_lo;  // cap scaled up, less half an LSB
        logic                   ok;      // configuration passes its checks
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [DEAD_W-1:0]             dead_left;
        logic                          standby_n;
        logic                          pin_a2;
        logic                          pin_a1;
        logic signed [DIR_W-1:0]       drive_dir;
        logic [TIMER_WIDTH-1:0]        ccr;
        logic [FAULT_W-1:0]            fault;
        logic [STATUS_W-1:0]           status;
    } t_result;

endpackage

`default_nettype wire

[sv/hbg_cfg.sv]
// Configuration register bank of the H-bridge guard.
// Holds the four registers and derives the duty cap, its rounding limit and
// the validity flag. Depends on hbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbg_cfg
    import hbg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    logic [TIMER_WIDTH-1:0] r_full_scale, n_full_scale;
    logic [DUTY_W-1:0]      r_max_duty, n_max_duty;
    logic [DEAD_W-1:0]      r_dead_ticks, n_dead_ticks;
    logic                   r_release_level, n_release_level;
    logic [CAP_W-1:0]       r_cap;
    logic [PROD_W-1:0]      n_prod;

    always_comb begin
        n_full_scale    = r_full_scale;
        n_max_duty      = r_max_duty;
        n_dead_ticks    = r_dead_ticks;
        n_release_level = r_release_level;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_FULL_SCALE:    n_full_scale    = i_cfg_data[TIMER_WIDTH-1:0];
                REG_MAX_DUTY:      n_max_duty      = i_cfg_data[DUTY_W-1:0];
                REG_DEAD_TICKS:    n_dead_ticks    = i_cfg_data[DEAD_W-1:0];
                REG_RELEASE_LEVEL: n_release_level = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The cap follows the registers written in the same cycle, so it is
    // always consistent with them.
    assign n_prod = PROD_W'(n_max_duty) * PROD_W'(n_full_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale    <= RST_FULL_SCALE;
            r_max_duty      <= RST_MAX_DUTY;
            r_dead_ticks    <= RST_DEAD_TICKS;
            r_release_level <= RST_RELEASE_LEVEL;
            r_cap           <= RST_CAP;
        end else begin
            r_full_scale    <= n_full_scale;
            r_max_duty      <= n_max_duty;
            r_dead_ticks    <= n_dead_ticks;
            r_release_level <= n_release_level;
            r_cap           <= n_prod[PROD_W-1:DUTY_FRAC_BITS];
        end
    end

    always_comb begin
        o_cfg.full_scale    = r_full_scale;
        o_cfg.max_duty      = r_max_duty;
        o_cfg.dead_ticks    = r_dead_ticks;
        o_cfg.release_level = r_release_level;
        o_cfg.cap           = r_cap;
        // cap * 2^F - 2^(F-1) is cap-1 followed by a one and F-1 zeros.
        o_cfg.lim_lo = (r_cap == '0) ? '0 :
                       {r_cap - CAP_W'(1), 1'b1, {(DUTY_FRAC_BITS-1){1'b0}}};
        o_cfg.ok = (r_full_scale != '0) && (r_max_duty != '0) &&
                   (r_max_duty <= DUTY_ONE) && (r_cap != '0) &&
                   (r_dead_ticks != '0);
    end

endmodule

`default_nettype wire

[sv/h_bridge_direction_pwm_guard_core.sv]
// Top level of the H-bridge direction and PWM guard.
// Instantiates hbg_cfg for the register bank and holds the guard state, the
// input register and the result register. Depends on hbg_pkg and hbg_cfg.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the slave stream is one control tick: an initialise
// command (tuser high) that checks the configuration and arms the guard, or an
// update command carrying a requested direction, a Q1.16 duty and a
// permission. Every tick produces exactly one result transfer on the master
// stream with the bridge pin levels, the standby enable, the PWM compare value
// and the number of safe ticks still needed before a held-off reversal may be
// driven. The block takes one tick per clock cycle while the master stream
// does not stall: a tick is registered at the transfer, evaluated against
// the guard state once the result register is free or being emptied, and
// written to the result register, from which its result is offered on the
// master stream. The rate is set by the update of the guard state and by
// the single duty times full-scale multiplier that
// feeds the rounding compare. The result register decouples the two sides:
// while a result waits, one more tick is still taken into the input
// register. Configuration is written through a plain write port (register 0
// full scale, 1 maximum duty, 2 dead ticks, 3 release level) and must only be
// written while no tick is in flight. There is no clearing pass after reset.

module h_bridge_direction_pwm_guard_core
    import hbg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Slave stream: control ticks.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, lowest bit up: direction[1:0], duty[18:2], permission[20:19]
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[0]
    input  wire logic                  s_axis_tuser,
    // Master stream: results.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata, lowest bit up: status[1:0], fault[4:2], ccr[20:5],
    // drive_direction[22:21], pin_a1[23], pin_a2[24], standby_n[25],
    // dead_left[41:26]
    output logic [M_TDATA_W-1:0]       m_axis_tdata
);

    t_cfg cfg;

    hbg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Rounding offset of half an LSB of the compare value.
    localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << (DUTY_FRAC_BITS-1);

    // Input register.
    logic                    r_in_valid;
    logic                    r_in_opcode;
    logic signed [DIR_W-1:0] r_in_dir;
    logic [DUTY_W-1:0]       r_in_duty;
    logic [PERM_W-1:0]       r_in_perm;

    // Guard state.
    logic                    r_armed, n_armed;
    logic signed [DIR_W-1:0] r_last_dir, n_last_dir;
    logic signed [DIR_W-1:0] r_pend_dir, n_pend_dir;
    logic [DEAD_W-1:0]       r_safe_cnt, n_safe_cnt;
    logic [DEAD_W-1:0]       r_dead_rem, n_dead_rem;

    // Result register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic advance;

    // The tick in the input register moves on whenever the result register
    // is free or is being emptied in this cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Compare value: rounded duty * full_scale, capped, at least one.
    logic [PROD_W-1:0]      prod;
    logic [PROD_W:0]        rnd;
    logic [CAP_W:0]         rnd_q;
    logic [TIMER_WIDTH-1:0] ccr_val;

    assign prod  = PROD_W'(r_in_duty) * PROD_W'(cfg.full_scale);
    assign rnd   = (PROD_W+1)'(prod) + RND_HALF;
    assign rnd_q = rnd[PROD_W:DUTY_FRAC_BITS];

    always_comb begin
        if (prod >= cfg.lim_lo) begin
            ccr_val = cfg.cap[TIMER_WIDTH-1:0];
        end else if (rnd_q == '0) begin
            ccr_val = TIMER_WIDTH'(1);
        end else begin
            ccr_val = rnd_q[TIMER_WIDTH-1:0];
        end
    end

    // Consistency of the guard state with the present dead_ticks setting.
    logic state_ok;

    always_comb begin
        if ((r_last_dir == DIR_BAD) || (r_pend_dir == DIR_BAD) ||
            (r_dead_rem > cfg.dead_ticks) || (r_safe_cnt > cfg.dead_ticks)) begin
            state_ok = 1'b0;
        end else if (r_last_dir == DIR_NONE) begin
            state_ok = (r_pend_dir == DIR_NONE) && (r_dead_rem == '0) &&
                       (r_safe_cnt == '0);
        end else if (r_pend_dir == DIR_NONE) begin
            state_ok = (r_dead_rem == '0);
        end else begin
            state_ok = (r_pend_dir == -r_last_dir) && (r_safe_cnt != '0) &&
                       (r_dead_rem == cfg.dead_ticks - r_safe_cnt);
        end
    end

    // Evaluation of one tick.
    always_comb begin
        logic [FAULT_W-1:0]      fault_code;
        logic                    do_count;
        logic signed [DIR_W-1:0] cnt_pend;

        n_armed    = r_armed;
        n_last_dir = r_last_dir;
        n_pend_dir = r_pend_dir;
        n_safe_cnt = r_safe_cnt;
        n_dead_rem = r_dead_rem;
        n_out      = '0;
        fault_code = FLT_NONE;
        do_count   = 1'b0;
        cnt_pend   = r_pend_dir;

        if (r_in_opcode == OP_INIT) begin
            n_last_dir = DIR_NONE;
            n_pend_dir = DIR_NONE;
            n_safe_cnt = '0;
            n_dead_rem = '0;
            if (cfg.ok) begin
                n_armed      = 1'b1;
                n_out.status = ST_SAFE;
            end else begin
                n_armed      = 1'b0;
                n_out.status = ST_ERROR;
                n_out.fault  = FLT_CONFIG;
            end
        end else begin
            // Faults are checked in priority order.
            if (!r_armed) begin
                fault_code = FLT_NOT_ARMED;
            end else if (!cfg.ok) begin
                fault_code = FLT_CONFIG;
            end else if (!state_ok) begin
                fault_code = FLT_STATE;
            end else if (r_in_perm > PERM_ALLOW) begin
                fault_code = FLT_PERM;
            end else if (r_in_duty > cfg.max_duty) begin
                fault_code = FLT_DUTY;
            end else if ((r_in_dir == DIR_BAD) ||
                         ((r_in_perm == PERM_ALLOW) && (r_in_dir == DIR_NONE))) begin
                fault_code = FLT_DIR;
            end

            if (fault_code != FLT_NONE) begin
                // Any fault disarms the guard and drops all state.
                n_armed      = 1'b0;
                n_last_dir   = DIR_NONE;
                n_pend_dir   = DIR_NONE;
                n_safe_cnt   = '0;
                n_dead_rem   = '0;
                n_out.status = ST_ERROR;
                n_out.fault  = fault_code;
            end else if ((r_in_perm == PERM_SAFE) || (r_in_duty == '0)) begin
                do_count = 1'b1;
            end else if ((r_last_dir != DIR_NONE) && (r_in_dir != r_last_dir) &&
                         (r_safe_cnt < cfg.dead_ticks)) begin
                // Reversal requested too early: hold it off.
                cnt_pend   = r_in_dir;
                n_pend_dir = r_in_dir;
                do_count   = 1'b1;
            end else begin
                n_last_dir      = r_in_dir;
                n_pend_dir      = DIR_NONE;
                n_safe_cnt      = '0;
                n_dead_rem      = '0;
                n_out.status    = ST_ACTIVE;
                n_out.ccr       = ccr_val;
                n_out.drive_dir = r_in_dir;
                n_out.pin_a1    = (r_in_dir == DIR_FWD) ? cfg.release_level
                                                        : !cfg.release_level;
                n_out.pin_a2    = (r_in_dir == DIR_FWD) ? !cfg.release_level
                                                        : cfg.release_level;
                n_out.standby_n = 1'b1;
            end

            if (do_count) begin
                // The safe tick count saturates at dead_ticks.
                if ((r_last_dir != DIR_NONE) && (r_safe_cnt < cfg.dead_ticks)) begin
                    n_safe_cnt = r_safe_cnt + DEAD_W'(1);
                end
                n_dead_rem      = (cnt_pend != DIR_NONE) ? cfg.dead_ticks - n_safe_cnt
                                                         : '0;
                n_out.status    = ST_SAFE;
                n_out.dead_left = n_dead_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_armed     <= 1'b0;
            r_last_dir  <= DIR_NONE;
            r_pend_dir  <= DIR_NONE;
            r_safe_cnt  <= '0;
            r_dead_rem  <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_armed     <= n_armed;
                r_last_dir  <= n_last_dir;
                r_pend_dir  <= n_pend_dir;
                r_safe_cnt  <= n_safe_cnt;
                r_dead_rem  <= n_dead_rem;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_opcode <= s_axis_tuser;
            r_in_dir    <= s_axis_tdata[DIR_W-1:0];
            r_in_duty   <= s_axis_tdata[DIR_W +: DUTY_W];
            r_in_perm   <= s_axis_tdata[DIR_W+DUTY_W +: PERM_W];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out.dead_left, r_out.standby_n, r_out.pin_a2,
                                       r_out.pin_a1, r_out.drive_dir, r_out.ccr,
                                       r_out.fault, r_out.status});

endmodule

`default_nettype wire

[sv/hbg_checker.sv]
// Port-level checker for the H-bridge guard, bound to the top level.
// Watches the result stream for consistent bridge outputs and handshake
// behaviour. Depends on hbg_pkg and h_bridge_direction_pwm_guard_core.
`timescale 1ns / 1ps
`default_nettype none

module hbg_checker
    import hbg_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0]    status;
    logic [FAULT_W-1:0]     fault;
    logic [TIMER_WIDTH-1:0] ccr;
    logic [DIR_W-1:0]       drive_dir;
    logic                   pin_a1;
    logic                   pin_a2;
    logic                   standby_n;
    logic [DEAD_W-1:0]      dead_left;

    assign status    = m_axis_tdata[M_POS_STATUS +: STATUS_W];
    assign fault     = m_axis_tdata[M_POS_FAULT +: FAULT_W];
    assign ccr       = m_axis_tdata[M_POS_CCR +: TIMER_WIDTH];
    assign drive_dir = m_axis_tdata[M_POS_DIR +: DIR_W];
    assign pin_a1    = m_axis_tdata[M_POS_A1];
    assign pin_a2    = m_axis_tdata[M_POS_A2];
    assign standby_n = m_axis_tdata[M_POS_STBY];
    assign dead_left = m_axis_tdata[M_POS_DEAD +: DEAD_W];

    // A driving result energises the bridge with opposite pin levels, a
    // nonzero direction and a nonzero compare value.
    a_active_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status == ST_ACTIVE)) |->
            (standby_n && (pin_a1 != pin_a2) && (drive_dir != DIR_NONE) &&
             (ccr != '0) && (dead_left == '0)))
        else $error("active result with inconsistent bridge outputs");

    // Any result that is not driving leaves the bridge fully released.
    a_safe_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status != ST_ACTIVE)) |->
            (!standby_n && !pin_a1 && !pin_a2 && (drive_dir == DIR_NONE) &&
             (ccr == '0)))
        else $error("bridge energised outside an active result");

    // A fault code appears exactly with an error status, and errors report
    // no pending dead time.
    a_fault_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (((status == ST_ERROR) == (fault != FLT_NONE)) &&
             ((status != ST_ERROR) || (dead_left == '0))))
        else $error("fault code and status disagree");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind h_bridge_direction_pwm_guard_core hbg_checker u_hbg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[sim/hbg_guard_checker.sv]
// Checker for the H-bridge direction and PWM guard: watches the configuration
// port and both streams, predicts every result and compares it field by field.
// Depends on hbg_pkg for widths, codes and the result layout.
`timescale 1ns / 1ps

module hbg_guard_checker
    import hbg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_tick_valid,
    input  wire logic                  i_tick_ready,
    // direction, duty, permission from the lowest bit up
    input  wire logic [S_TDATA_W-1:0]  i_tick_data,
    // opcode
    input  wire logic                  i_tick_user,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_ready,
    // status, fault, ccr, drive_direction, pin_a1, pin_a2, standby_n,
    // dead_left from the lowest bit up
    input  wire logic [M_TDATA_W-1:0]  i_res_data,
    output int                         o_fail_count,
    output int                         o_waiting,
    output int                         o_active,
    output int                         o_safe,
    output int                         o_error,
    output int                         o_held
);

    // Mirror of the register bank.
    logic [TIMER_WIDTH-1:0] cfg_full_scale;
    logic [DUTY_W-1:0]      cfg_max_duty;
    logic [DEAD_W-1:0]      cfg_dead_ticks;
    logic                   cfg_release;

    // Guard state as the block should hold it.
    logic                    g_armed;
    logic signed [DIR_W-1:0] g_last_dir;
    logic signed [DIR_W-1:0] g_pending_dir;
    logic [DEAD_W-1:0]       g_safe_count;
    logic [DEAD_W-1:0]       g_dead_remaining;

    t_result bridge_results_q[$];
    int      result_index = 0;

    function automatic longint unsigned cap_counts();
        return (64'(cfg_max_duty) * 64'(cfg_full_scale)) >> DUTY_FRAC_BITS;
    endfunction

    function automatic bit config_valid();
        return cfg_full_scale != 0 && cfg_max_duty != 0 && cfg_max_duty <= DUTY_ONE &&
               cap_counts() != 0 && cfg_dead_ticks != 0;
    endfunction

    task automatic clear_guard();
        g_armed          = 1'b0;
        g_last_dir       = DIR_NONE;
        g_pending_dir    = DIR_NONE;
        g_safe_count     = '0;
        g_dead_remaining = '0;
    endtask

    // A safe tick only counts towards a reversal once something was energised.
    task automatic count_safe_tick();
        if (g_last_dir != DIR_NONE && g_safe_count < cfg_dead_ticks)
            g_safe_count = g_safe_count + 1'b1;
        g_dead_remaining = (g_pending_dir != DIR_NONE) ? cfg_dead_ticks - g_safe_count : '0;
    endtask

    task automatic advance_guard(input logic op, input logic signed [DIR_W-1:0] dir,
                                 input logic [DUTY_W-1:0] duty,
                                 input logic [PERM_W-1:0] perm, output t_result r);
        longint unsigned     cap;
        longint unsigned     prod;
        longint unsigned     lim;
        longint unsigned     rounded;
        bit                  state_good;
        logic [FAULT_W-1:0]  fault;
        logic                pin;
        r = '0;
        if (op == OP_INIT) begin
            clear_guard();
            if (config_valid()) begin
                g_armed = 1'b1;
            end else begin
                r.status = ST_ERROR;
                r.fault  = FLT_CONFIG;
            end
        end else begin
            if (g_last_dir == DIR_BAD || g_pending_dir == DIR_BAD ||
                g_dead_remaining > cfg_dead_ticks || g_safe_count > cfg_dead_ticks)
                state_good = 1'b0;
            else if (g_last_dir == DIR_NONE)
                state_good = g_pending_dir == DIR_NONE && g_dead_remaining == 0 &&
                             g_safe_count == 0;
            else if (g_pending_dir == DIR_NONE)
                state_good = g_dead_remaining == 0;
            else
                state_good = g_pending_dir == -g_last_dir && g_safe_count != 0 &&
                             g_dead_remaining == cfg_dead_ticks - g_safe_count;

            fault = FLT_NONE;
            if (!g_armed)
                fault = FLT_NOT_ARMED;
            else if (!config_valid())
                fault = FLT_CONFIG;
            else if (!state_good)
                fault = FLT_STATE;
            else if (perm > PERM_ALLOW)
                fault = FLT_PERM;
            else if (duty > cfg_max_duty)
                fault = FLT_DUTY;
            else if (dir == DIR_BAD || (perm == PERM_ALLOW && dir == DIR_NONE))
                fault = FLT_DIR;

            if (fault != FLT_NONE) begin
                clear_guard();
                r.status = ST_ERROR;
                r.fault  = fault;
            end else if (perm == PERM_SAFE || duty == 0) begin
                count_safe_tick();
                r.dead_left = g_dead_remaining;
            end else if (g_last_dir != DIR_NONE && dir != g_last_dir &&
                         g_safe_count < cfg_dead_ticks) begin
                // Reversal held off until enough safe ticks have passed.
                g_pending_dir = dir;
                count_safe_tick();
                r.dead_left = g_dead_remaining;
                o_held++;
            end else begin
                cap     = cap_counts();
                prod    = 64'(duty) * 64'(cfg_full_scale);
                lim     = cap << DUTY_FRAC_BITS;
                rounded = prod + (64'd1 << (DUTY_FRAC_BITS - 1));
                if (prod >= lim || rounded >= lim)
                    r.ccr = TIMER_WIDTH'(cap);
                else if ((rounded >> DUTY_FRAC_BITS) == 0)
                    r.ccr = TIMER_WIDTH'(1);
                else
                    r.ccr = TIMER_WIDTH'(rounded >> DUTY_FRAC_BITS);
                pin              = (dir == DIR_FWD) ? cfg_release : ~cfg_release;
                r.status         = ST_ACTIVE;
                r.drive_dir      = dir;
                r.pin_a1         = pin;
                r.pin_a2         = ~pin;
                r.standby_n      = 1'b1;
                g_last_dir       = dir;
                g_pending_dir    = DIR_NONE;
                g_safe_count     = '0;
                g_dead_remaining = '0;
            end
        end
        case (r.status)
            ST_ACTIVE: o_active++;
            ST_SAFE:   o_safe++;
            default:   o_error++;
        endcase
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("[%0t] result %0d: %s expected %0d, got %0d",
                         $time, result_index, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result predicted;
        t_result observed;
        if (!i_rst_n) begin
            cfg_full_scale = RST_FULL_SCALE;
            cfg_max_duty   = RST_MAX_DUTY;
            cfg_dead_ticks = RST_DEAD_TICKS;
            cfg_release    = RST_RELEASE_LEVEL;
            clear_guard();
            bridge_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    REG_FULL_SCALE:    cfg_full_scale = i_cfg_data[TIMER_WIDTH-1:0];
                    REG_MAX_DUTY:      cfg_max_duty   = i_cfg_data[DUTY_W-1:0];
                    REG_DEAD_TICKS:    cfg_dead_ticks = i_cfg_data[DEAD_W-1:0];
                    REG_RELEASE_LEVEL: cfg_release    = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_res_valid && i_res_ready) begin
                observed = t_result'(i_res_data[$bits(t_result)-1:0]);
                if (bridge_results_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] result %0d arrived with nothing predicted: %h",
                                 $time, result_index, i_res_data);
                end else begin
                    predicted = bridge_results_q.pop_front();
                    check_field("status", predicted.status, observed.status);
                    check_field("fault", predicted.fault, observed.fault);
                    check_field("ccr", predicted.ccr, observed.ccr);
                    check_field("drive_direction", $unsigned(predicted.drive_dir),
                                $unsigned(observed.drive_dir));
                    check_field("pin_a1", predicted.pin_a1, observed.pin_a1);
                    check_field("pin_a2", predicted.pin_a2, observed.pin_a2);
                    check_field("standby_n", predicted.standby_n, observed.standby_n);
                    check_field("dead_left", predicted.dead_left, observed.dead_left);
                    check_field("padding", 0, i_res_data[M_TDATA_W-1:$bits(t_result)]);
                end
                result_index++;
            end

            if (i_tick_valid && i_tick_ready) begin
                advance_guard(i_tick_user, i_tick_data[DIR_W-1:0],
                              i_tick_data[DIR_W +: DUTY_W],
                              i_tick_data[DIR_W + DUTY_W +: PERM_W], predicted);
                bridge_results_q.push_back(predicted);
            end
        end
        o_waiting = bridge_results_q.size();
    end

endmodule

[sim/h_bridge_direction_pwm_guard_core_test.sv]
// Testbench top for the H-bridge direction and PWM guard core: drives ticks,
// configuration and back-pressure, and gives the verdict.
// Depends on hbg_pkg, h_bridge_direction_pwm_guard_core and hbg_guard_checker.
`timescale 1ns / 1ps

module h_bridge_direction_pwm_guard_core_test;
    import hbg_pkg::*;

    localparam int     HALF_PERIOD   = 5;
    localparam int     LONG_HOLD     = 40;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_TICKS   = 100;
    // Far beyond the slowest legal run, in which every tick meets the longest
    // sender gap and the longest receiver stall.
    localparam longint TIMEOUT_NS    = 5_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // direction[1:0], duty[18:2], permission[20:19]
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    // opcode[0]
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // status, fault, ccr, drive_direction, pin_a1, pin_a2, standby_n, dead_left
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int fail_count;
    int waiting;
    int n_active;
    int n_safe;
    int n_error;
    int n_held;
    int ticks_sent = 0;

    // Stimulus controls for the sender and the receiver process.
    bit                      send_idle;
    bit                      recv_stall;
    bit                      hold_req;
    logic signed [DIR_W-1:0] cur_dir;
    logic [DUTY_W-1:0]       cfg_md;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    h_bridge_direction_pwm_guard_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hbg_guard_checker u_guard_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_tick_valid (s_axis_tvalid),
        .i_tick_ready (s_axis_tready),
        .i_tick_data  (s_axis_tdata),
        .i_tick_user  (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_active     (n_active),
        .o_safe       (n_safe),
        .o_error      (n_error),
        .o_held       (n_held)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    // Duties weighted towards zero, the permitted maximum and the values that
    // round down to nothing, so that the cap and the floor of one are both hit.
    function automatic logic [DUTY_W-1:0] pick_duty(input logic [DUTY_W-1:0] top_duty);
        logic [DUTY_W-1:0] lim;
        int                r;
        lim = (top_duty > DUTY_ONE || top_duty == 0) ? DUTY_ONE : top_duty;
        r   = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 18)
            return lim;
        if (r < 28)
            return DUTY_W'($urandom_range(1, 4));
        return DUTY_W'($urandom_range(1, lim));
    endfunction

    // Offers one tick from a falling edge and returns at the falling edge after
    // its transfer, with tvalid still high so that back-to-back ticks need no
    // second assignment in the same step.
    task automatic send_tick(input logic op, input logic signed [DIR_W-1:0] dir,
                             input logic [DUTY_W-1:0] duty, input logic [PERM_W-1:0] perm);
        int gap;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = S_TDATA_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = S_TDATA_W'({perm, duty, dir});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    // Stops offering and waits until every predicted result has arrived, then lets
    // the clock run on so that the block is certainly idle before a register write.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (waiting != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic set_config(input logic [TIMER_WIDTH-1:0] fs, input logic [DUTY_W-1:0] md,
                              input logic [DEAD_W-1:0] dt, input logic rl);
        write_reg(REG_FULL_SCALE, CFG_DATA_W'(fs));
        write_reg(REG_MAX_DUTY, CFG_DATA_W'(md));
        write_reg(REG_DEAD_TICKS, CFG_DATA_W'(dt));
        write_reg(REG_RELEASE_LEVEL, CFG_DATA_W'(rl));
        cfg_md = md;
    endtask

    // One random tick. Most are well-formed updates that keep driving or ask
    // for reversals; a few are initialises and a few are malformed, after
    // which an initialise usually follows so that the guard gets re-armed.
    task automatic send_random_tick(inout bit need_init);
        int                      r;
        logic signed [DIR_W-1:0] d;
        r = $urandom_range(0, 99);
        if (need_init || r < 6) begin
            send_tick(OP_INIT, DIR_W'($urandom), DUTY_W'($urandom), PERM_W'($urandom));
            need_init = 1'b0;
        end else if (r < 11) begin
            case ($urandom_range(0, 3))
                0: send_tick(OP_UPDATE, cur_dir, pick_duty(cfg_md),
                             PERM_W'($urandom_range(2, 3)));
                1: send_tick(OP_UPDATE, cur_dir, DUTY_W'($urandom_range(65537, 131071)),
                             PERM_ALLOW);
                2: send_tick(OP_UPDATE, DIR_BAD, pick_duty(cfg_md),
                             PERM_W'($urandom_range(0, 1)));
                default: send_tick(OP_UPDATE, DIR_NONE, pick_duty(cfg_md), PERM_ALLOW);
            endcase
            need_init = ($urandom_range(0, 9) != 0);
        end else if (r < 35) begin
            case ($urandom_range(0, 2))
                0:       d = DIR_NONE;
                1:       d = cur_dir;
                default: d = -cur_dir;
            endcase
            send_tick(OP_UPDATE, d, pick_duty(cfg_md), PERM_SAFE);
        end else begin
            if ($urandom_range(0, 99) < 25)
                cur_dir = -cur_dir;
            send_tick(OP_UPDATE, cur_dir, pick_duty(cfg_md), PERM_ALLOW);
        end
    endtask

    // Receiver: random stalls, and on request one long hold-off counted here
    // while the sender keeps offering, so that both registers fill and the
    // block has to drop tready on its input.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (recv_stall && $urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat (pick_gap()) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d results still outstanding.", waiting);
        $display("h_bridge_direction_pwm_guard_core: mismatch");
        $finish;
    end

    initial begin
        bit need_init;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_UPDATE;
        send_idle     = 1'b1;
        recv_stall    = 1'b1;
        hold_req      = 1'b0;
        cur_dir       = DIR_FWD;
        cfg_md        = RST_MAX_DUTY;
        need_init     = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part on the reset configuration: full scale 1000, maximum
        // duty 1.0, one dead tick, forward drives pin A1 low.
        send_tick(OP_UPDATE, DIR_FWD, 17'd32768, PERM_ALLOW);   // not yet armed
        send_tick(OP_INIT, DIR_BAD, 17'h1FFFF, 2'd3);           // fields are ignored
        send_tick(OP_UPDATE, DIR_FWD, DUTY_ONE, PERM_ALLOW);    // clamped to the cap
        send_tick(OP_UPDATE, DIR_REV, 17'd32768, PERM_ALLOW);   // reversal held off
        send_tick(OP_UPDATE, DIR_REV, 17'd1, PERM_ALLOW);       // rounds to zero, raised to 1
        send_tick(OP_UPDATE, DIR_NONE, 17'd0, PERM_SAFE);       // plain safe tick
        send_tick(OP_UPDATE, DIR_REV, 17'd65503, PERM_ALLOW);   // just below the cap
        send_tick(OP_UPDATE, DIR_FWD, 17'd0, PERM_ALLOW);       // zero duty is safe
        send_tick(OP_UPDATE, DIR_NONE, 17'd100, PERM_ALLOW);    // no direction yet allowed
        send_tick(OP_INIT, DIR_NONE, 17'd0, PERM_SAFE);
        send_tick(OP_UPDATE, DIR_FWD, 17'd100, 2'd2);           // bad permission
        send_tick(OP_INIT, DIR_NONE, 17'd0, PERM_SAFE);
        send_tick(OP_UPDATE, DIR_FWD, 17'd65537, PERM_ALLOW);   // duty above the maximum
        send_tick(OP_INIT, DIR_NONE, 17'd0, PERM_SAFE);
        send_tick(OP_UPDATE, DIR_BAD, 17'd0, PERM_SAFE);        // invalid direction

        // Longer dead time, widest timer, forward drives pin A1 high.
        drain();
        set_config(16'd65535, DUTY_ONE, 16'd3, 1'b1);
        send_tick(OP_INIT, DIR_NONE, 17'd0, PERM_SAFE);
        send_tick(OP_UPDATE, DIR_FWD, DUTY_ONE, PERM_ALLOW);
        send_tick(OP_UPDATE, DIR_REV, 17'd40000, PERM_ALLOW);   // held, two to go
        send_tick(OP_UPDATE, DIR_NONE, 17'd0, PERM_SAFE);
        send_tick(OP_UPDATE, DIR_REV, 17'd40000, PERM_ALLOW);   // held, count runs out
        send_tick(OP_UPDATE, DIR_REV, 17'd40000, PERM_ALLOW);   // reversal now driven
        send_tick(OP_UPDATE, DIR_NONE, 17'd0, PERM_SAFE);
        send_tick(OP_UPDATE, DIR_NONE, 17'd0, PERM_SAFE);

        // Dead time lowered below the safe count while armed: state fault.
        drain();
        write_reg(REG_DEAD_TICKS, CFG_DATA_W'(1));
        send_tick(OP_UPDATE, DIR_REV, 17'd500, PERM_ALLOW);
        send_tick(OP_INIT, DIR_NONE, 17'd0, PERM_SAFE);

        // Configuration spoiled while armed, then rejected at initialise.
        drain();
        set_config(16'd65535, 17'h1FFFF, 16'd1, 1'b0);
        send_tick(OP_UPDATE, DIR_FWD, 17'd500, PERM_ALLOW);
        send_tick(OP_INIT, DIR_NONE, 17'd0, PERM_SAFE);
        drain();
        set_config(16'd1, 17'd2, 16'd0, 1'b0);                 // zero cap, zero dead time
        send_tick(OP_INIT, DIR_NONE, 17'd0, PERM_SAFE);

        // Random phases. Some phases keep the guard armed across the register
        // writes instead of initialising, and some run without any idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph)
                0: set_config(16'd65535, DUTY_ONE, 16'd1, 1'b1);
                1: set_config(16'd1, DUTY_ONE, 16'd2, 1'b0);
                2: set_config(16'd65535, 17'd2, 16'd65535, 1'b1);
                7: set_config(16'd0, 17'd0, 16'd0, 1'b1);
                default: set_config(TIMER_WIDTH'($urandom_range(1, 65535)),
                                    ($urandom_range(0, 9) < 7) ?
                                        DUTY_W'($urandom_range(1, 65536)) : DUTY_ONE,
                                    ($urandom_range(0, 9) < 8) ?
                                        DEAD_W'($urandom_range(1, 5)) :
                                        DEAD_W'($urandom_range(1, 65535)),
                                    1'($urandom));
            endcase
            send_idle  = (ph % 4 != 1);
            recv_stall = (ph % 4 != 1) && (ph % 4 != 3);
            need_init  = (ph % 3 != 2);
            for (int k = 0; k < PHASE_TICKS; k++) begin
                if (ph == 4 && k == PHASE_TICKS / 2) begin
                    // Long receiver hold-off against a sender that never idles.
                    hold_req  = 1'b1;
                    send_idle = 1'b0;
                    repeat (12) send_random_tick(need_init);
                    send_idle = 1'b1;
                end
                send_random_tick(need_init);
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d ticks over %0d register settings; predicted %0d active, %0d safe",
                 ticks_sent, RANDOM_PHASES + 4, n_active, n_safe);
        $display("and %0d error results, with %0d reversals held off by the dead time.",
                 n_error, n_held);
        if (fail_count == 0 && waiting == 0)
            $display("h_bridge_direction_pwm_guard_core: match");
        else
            $display("h_bridge_direction_pwm_guard_core: mismatch");
        $finish;
    end

endmodule

[sim.f]
sv/hbg_pkg.sv
sv/hbg_cfg.sv
sv/h_bridge_direction_pwm_guard_core.sv
sv/hbg_checker.sv
sim/hbg_guard_checker.sv
sim/h_bridge_direction_pwm_guard_core_test.sv
